FILE: rtl/sbs_pkg.sv
`timescale 1ns / 1ps

package sbs_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int SLOT_W      = 10;
	localparam int POS_W       = 10;
	localparam int COUNT_W     = 11;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 16;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} sbs_mem_req_t;

endpackage

FILE: rtl/sbs_table_ram.sv
`timescale 1ns / 1ps

module sbs_table_ram
	import sbs_pkg::*;
(
	input  logic              clk,
	input  sbs_mem_req_t      req,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

FILE: rtl/sbs_search_fsm.sv
`timescale 1ns / 1ps

module sbs_search_fsm
	import sbs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_cmd,
	input  logic [SLOT_W-1:0] in_slot,
	input  logic [DATA_W-1:0] in_value,
	input  logic [CNT_W-1:0]  n,
	input  logic [DATA_W-1:0] rd_data,
	output sbs_mem_req_t      mem_req,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              out_found,
	output logic [POS_W-1:0]  out_pos
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_PROBE  = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t                    state_q, state_n;
	logic [CNT_W-1:0]          lo_q, lo_n;
	logic [CNT_W-1:0]          hi_q, hi_n;    // exclusive upper bound
	logic [ADDR_W-1:0]         mid_q, mid_n;
	logic signed [DATA_W-1:0]  key_q;
	logic                      res_found_q, res_found_n;
	logic [POS_W-1:0]          res_pos_q, res_pos_n;
	logic                      out_valid_q;
	logic                      out_found_q;
	logic [POS_W-1:0]          out_pos_q;
	logic                      out_free;
	logic signed [DATA_W-1:0]  probe;
	logic [CNT_W-1:0]          span;
	logic [ADDR_W-1:0]         mid0;

	assign out_free = !out_valid_q || out_ready;
	assign probe    = $signed(rd_data);
	assign in_ready = (state_q == ST_IDLE);
	assign mid0     = ADDR_W'((n - CNT_W'(1)) >> 1);

	always_comb begin
		state_n       = state_q;
		lo_n          = lo_q;
		hi_n          = hi_q;
		mid_n         = mid_q;
		res_found_n   = res_found_q;
		res_pos_n     = res_pos_q;
		span          = '0;
		mem_req.we    = 1'b0;
		mem_req.waddr = ADDR_W'(in_slot);
		mem_req.wdata = in_value;
		mem_req.re    = 1'b0;
		mem_req.raddr = mid0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_LOAD) begin
						mem_req.we = (32'(in_slot) < 32'(TABLE_DEPTH));
					end else if (n == '0) begin
						res_found_n = 1'b0;
						res_pos_n   = '0;
						state_n     = ST_RESULT;
					end else begin
						lo_n       = '0;
						hi_n       = n;
						mid_n      = mid0;
						mem_req.re = 1'b1;
						state_n    = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				// rd_data holds the slot at mid_q
				if (probe == key_q) begin
					res_found_n = 1'b1;
					res_pos_n   = POS_W'(mid_q);
					state_n     = ST_RESULT;
				end else begin
					if (probe > key_q) begin
						hi_n = CNT_W'(mid_q);
					end else begin
						lo_n = CNT_W'(mid_q) + CNT_W'(1);
					end
					if (lo_n >= hi_n) begin
						res_found_n = 1'b0;
						res_pos_n   = '0;
						state_n     = ST_RESULT;
					end else begin
						span          = hi_n - lo_n - CNT_W'(1);
						mid_n         = ADDR_W'(lo_n + (span >> 1));
						mem_req.re    = 1'b1;
						mem_req.raddr = mid_n;
					end
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q        <= lo_n;
		hi_q        <= hi_n;
		mid_q       <= mid_n;
		res_found_q <= res_found_n;
		res_pos_q   <= res_pos_n;
		if (state_q == ST_IDLE && in_valid) begin
			key_q <= $signed(in_value);
		end
		if (state_q == ST_RESULT && out_free) begin
			out_found_q <= res_found_q;
			out_pos_q   <= res_pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_pos   = out_pos_q;

endmodule

FILE: rtl/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Channel   | Direction | Fields
// s_*       | in        | tuser: cmd; tdata: slot [9:0], value [41:10], zero pad
// m_*       | out       | tuser: found; tdata: position [9:0], zero pad
// cfg_*     | in        | cfg_wdata: element_count
//
// Load beat: written straight into the table RAM.
// Search beat: an accept step, one probe per RAM read (until the key matches
// or the search range is empty), then a result step.
// The probe loop is bounded by the table RAM's registered read port.
// Reset clears control and element_count; the table holds garbage until loaded.
// s_tready drops while a search runs or its result waits for the output register.

module sorted_table_binary_search
	import sbs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // slot [9:0], value [41:10]
	input  logic                 s_tuser,   // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // position [9:0]
	output logic                 m_tuser,   // found
	input  logic                 cfg_we,
	input  logic [COUNT_W-1:0]   cfg_wdata
);

	logic [COUNT_W-1:0] count_q;
	logic [CNT_W-1:0]   n;
	sbs_mem_req_t       mem_req;
	logic [DATA_W-1:0]  rd_data;
	logic [POS_W-1:0]   pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// counts beyond the table saturate at its depth
	assign n = (32'(count_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_q);

	sbs_table_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rd_data)
	);

	sbs_search_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tuser),
		.in_slot   (s_tdata[SLOT_W-1:0]),
		.in_value  (s_tdata[SLOT_W +: DATA_W]),
		.n         (n),
		.rd_data   (rd_data),
		.mem_req   (mem_req),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_found (m_tuser),
		.out_pos   (pos)
	);

	assign m_tdata = {{(M_TDATA_W - POS_W){1'b0}}, pos};

`ifndef SYNTH
	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> pos == '0)
		else $error("miss result with nonzero position");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("table read and write in the same cycle");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> s_tready && s_tvalid && s_tuser == CMD_LOAD)
		else $error("table write outside an accepted load beat");
`endif

endmodule
